/* rtl/crcfc_pkg.sv */
package crcfc_pkg;

  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;
  localparam int unsigned HDR_LEN  = 10;
  localparam int unsigned TRL_LEN  = 4;
  localparam int unsigned POS_W    = 17;
  localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

  localparam logic [1:0] CFG_START_FIRST  = 2'd0;
  localparam logic [1:0] CFG_START_SECOND = 2'd1;
  localparam logic [1:0] CFG_VERSION      = 2'd2;
  localparam logic [1:0] CFG_FLAG_MASK    = 2'd3;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FORMAT  = 2'd1,
    ST_VERSION = 2'd2,
    ST_CRC     = 2'd3
  } status_t;

  typedef struct packed {
    logic [7:0] start_first;
    logic [7:0] start_second;
    logic [7:0] version;
    logic [7:0] flag_mask;
  } cfg_t;

  typedef struct packed {
    logic        is_frame_end;
    logic [7:0]  payload_byte;
    status_t     status;
    logic [7:0]  opcode;
    logic [7:0]  frame_flags;
    logic [15:0] xact_id;
    logic [15:0] payload_length;
  } res_t;

  // byte-wide reflected CRC-32 update, unrolled
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

/* rtl/crcfc_parser.sv */
module crcfc_parser #(
  parameter int unsigned MAX_PAYLOAD = 1024
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  logic [7:0]          data_byte,
  input  logic                last_byte,
  input  crcfc_pkg::cfg_t     cfg,
  output logic                res_valid,
  output crcfc_pkg::res_t     res
);

  localparam int unsigned PW = crcfc_pkg::POS_W;

  logic [PW-1:0] pos_r, pos_nxt;
  logic [31:0]   crc_r, crc_nxt;
  logic [31:0]   rcrc_r, rcrc_nxt;
  logic [7:0]    opc_r, opc_nxt;
  logic [7:0]    flg_r, flg_nxt;
  logic [15:0]   tid_r, tid_nxt;
  logic [15:0]   len_r, len_nxt;
  logic          start_bad_r, start_bad_nxt;
  logic          ver_bad_r, ver_bad_nxt;
  logic          hdr_bad_r, hdr_bad_nxt;

  logic [PW-1:0] pay_idx;
  logic [PW-1:0] count;
  logic [PW-1:0] exp_count;
  logic          len_ok;
  logic          forward;
  crcfc_pkg::status_t st;

  assign pay_idx = pos_r - PW'(crcfc_pkg::HDR_LEN);

  always_comb begin
    pos_nxt       = pos_r;
    crc_nxt       = crc_r;
    rcrc_nxt      = rcrc_r;
    opc_nxt       = opc_r;
    flg_nxt       = flg_r;
    tid_nxt       = tid_r;
    len_nxt       = len_r;
    start_bad_nxt = start_bad_r;
    ver_bad_nxt   = ver_bad_r;
    hdr_bad_nxt   = hdr_bad_r;
    forward       = 1'b0;

    case (pos_r)
      PW'(0): if (data_byte != cfg.start_first) start_bad_nxt = 1'b1;
      PW'(1): if (data_byte != cfg.start_second) start_bad_nxt = 1'b1;
      PW'(2): if (data_byte != cfg.version) ver_bad_nxt = 1'b1;
      PW'(3): opc_nxt = data_byte;
      PW'(4): begin
        flg_nxt = data_byte;
        if ((data_byte & ~cfg.flag_mask) != 8'd0) hdr_bad_nxt = 1'b1;
      end
      PW'(5): if (data_byte != 8'd0) hdr_bad_nxt = 1'b1;
      PW'(6): tid_nxt = {data_byte, tid_r[7:0]};
      PW'(7): tid_nxt = {tid_r[15:8], data_byte};
      PW'(8): len_nxt = {data_byte, len_r[7:0]};
      PW'(9): len_nxt = {len_r[15:8], data_byte};
      default: ;
    endcase

    len_ok = {1'b0, len_nxt} <= PW'(MAX_PAYLOAD);

    if (pos_r >= PW'(2) && pos_r < PW'(crcfc_pkg::HDR_LEN)) begin
      crc_nxt = crcfc_pkg::crc_byte(crc_r, data_byte);
    end else if (pos_r >= PW'(crcfc_pkg::HDR_LEN)) begin
      if (pay_idx < {1'b0, len_r}) begin
        crc_nxt = crcfc_pkg::crc_byte(crc_r, data_byte);
        forward = !start_bad_r && !ver_bad_r && !hdr_bad_r && len_ok;
      end else begin
        rcrc_nxt = {rcrc_r[23:0], data_byte};
      end
    end

    count     = (pos_r != crcfc_pkg::POS_MAX) ? pos_r + PW'(1) : crcfc_pkg::POS_MAX;
    pos_nxt   = count;
    exp_count = PW'(crcfc_pkg::HDR_LEN + crcfc_pkg::TRL_LEN) + {1'b0, len_nxt};

    if (count < PW'(crcfc_pkg::HDR_LEN + crcfc_pkg::TRL_LEN)) st = crcfc_pkg::ST_FORMAT;
    else if (start_bad_nxt)                                 st = crcfc_pkg::ST_FORMAT;
    else if (ver_bad_nxt)                                   st = crcfc_pkg::ST_VERSION;
    else if (hdr_bad_nxt)                                   st = crcfc_pkg::ST_FORMAT;
    else if (!len_ok || count != exp_count)                 st = crcfc_pkg::ST_FORMAT;
    else if (rcrc_nxt != ~crc_nxt)                          st = crcfc_pkg::ST_CRC;
    else                                                    st = crcfc_pkg::ST_OK;

    res.is_frame_end   = last_byte;
    res.payload_byte   = last_byte ? 8'd0 : data_byte;
    res.status         = last_byte ? st : crcfc_pkg::ST_OK;
    res.opcode         = opc_nxt;
    res.frame_flags    = flg_nxt;
    res.xact_id        = tid_nxt;
    res.payload_length = len_nxt;
    res_valid          = accept && (last_byte || forward);

    if (last_byte) begin
      pos_nxt       = '0;
      crc_nxt       = crcfc_pkg::CRC_INIT;
      rcrc_nxt      = '0;
      opc_nxt       = '0;
      flg_nxt       = '0;
      tid_nxt       = '0;
      len_nxt       = '0;
      start_bad_nxt = 1'b0;
      ver_bad_nxt   = 1'b0;
      hdr_bad_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      crc_r       <= crcfc_pkg::CRC_INIT;
      rcrc_r      <= '0;
      opc_r       <= '0;
      flg_r       <= '0;
      tid_r       <= '0;
      len_r       <= '0;
      start_bad_r <= 1'b0;
      ver_bad_r   <= 1'b0;
      hdr_bad_r   <= 1'b0;
    end else if (accept) begin
      pos_r       <= pos_nxt;
      crc_r       <= crc_nxt;
      rcrc_r      <= rcrc_nxt;
      opc_r       <= opc_nxt;
      flg_r       <= flg_nxt;
      tid_r       <= tid_nxt;
      len_r       <= len_nxt;
      start_bad_r <= start_bad_nxt;
      ver_bad_r   <= ver_bad_nxt;
      hdr_bad_r   <= hdr_bad_nxt;
    end
  end

endmodule

/* rtl/crc32_frame_checker_unit.sv */
// Results: the result word of an accepted input word is registered in out_res_r,
// or first in the skid entry while the output is stalled. Throughput: one input
// word per cycle while in_tready is high; the byte-wide CRC update and header
// checks are one combinational pass between frame state and the output register.
// Output register plus one skid entry; in_tready drops only while the skid is full.
// Reset: synchronous active-low rst_n clears frame state, config and buffer.
module crc32_frame_checker_unit #(
  parameter int unsigned MAX_PAYLOAD = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // last_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  // [7:0] payload_byte, [9:8] status, [17:10] opcode, [25:18] frame_flags,
  // [41:26] xact_id, [57:42] payload_length, [63:58] zero
  output logic [63:0] out_tdata,
  output logic        out_tuser,  // is_frame_end
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_wdata
);

  crcfc_pkg::cfg_t cfg_r;
  crcfc_pkg::res_t res;
  crcfc_pkg::res_t out_res_r, skid_res_r;
  logic            res_valid;
  logic            out_valid_r, skid_valid_r;
  logic            in_accept;
  logic            out_take;

  assign in_tready = !skid_valid_r;
  assign in_accept = in_tvalid && in_tready;
  assign out_take  = out_valid_r && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        crcfc_pkg::CFG_START_FIRST:  cfg_r.start_first  <= cfg_wdata;
        crcfc_pkg::CFG_START_SECOND: cfg_r.start_second <= cfg_wdata;
        crcfc_pkg::CFG_VERSION:      cfg_r.version      <= cfg_wdata;
        crcfc_pkg::CFG_FLAG_MASK:    cfg_r.flag_mask    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  crcfc_parser #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (in_accept),
    .data_byte(in_tdata),
    .last_byte(in_tlast),
    .cfg      (cfg_r),
    .res_valid(res_valid),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_take) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r  <= res_valid;
      end
    end else if (res_valid) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_take) begin
      out_res_r <= skid_valid_r ? skid_res_r : res;
    end else if (res_valid) begin
      skid_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.is_frame_end;
  assign out_tdata  = {6'd0, out_res_r.payload_length, out_res_r.xact_id,
                       out_res_r.frame_flags, out_res_r.opcode, out_res_r.status,
                       out_res_r.payload_byte};

`ifndef NO_ASSERTIONS
  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held while output register empty");

  a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r && !$past(skid_valid_r) |-> $past(out_valid_r && !out_tready && res_valid))
    else $error("skid filled without a stalled output");

  a_last_gives_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && in_tlast |-> res_valid && res.is_frame_end)
    else $error("last word produced no verdict");

  a_fwd_status_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_res_r.is_frame_end |-> out_res_r.status == crcfc_pkg::ST_OK)
    else $error("forwarded payload word carries a status");
`endif

endmodule
